// File: rtl/sdf_pkg.sv
// Package for the SD card data FIFO engine: opcodes, command kinds,
// register addresses and the structs passed between front and back.
// No dependencies.
`default_nettype none
package sdf_pkg;

   // Input opcodes.
   localparam logic [2:0] OP_START     = 3'd0;
   localparam logic [2:0] OP_CARD_IN   = 3'd1;
   localparam logic [2:0] OP_CARD_REQ  = 3'd2;
   localparam logic [2:0] OP_HOST_PUSH = 3'd3;
   localparam logic [2:0] OP_HOST_POP  = 3'd4;

   // Register indexes, taken from paddr[3:2].
   localparam logic [1:0] REG_DIRECTION = 2'd0;
   localparam logic [1:0] REG_LENGTH    = 2'd1;
   localparam logic [1:0] REG_HOLD      = 2'd2;

   localparam logic DIR_TO_CARD   = 1'b0;
   localparam logic DIR_FROM_CARD = 1'b1;

   localparam int WORD_BITS = 32;
   localparam int BYTE_BITS = 8;
   localparam int LEN_BITS  = 16;
   localparam int CNT_OUT_BITS = 5;
   localparam logic [2:0] BYTES_PER_WORD = 3'd4;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_START,
      CMD_CARD_IN,
      CMD_CARD_REQ,
      CMD_HOST_PUSH,
      CMD_HOST_POP
   } cmd_kind_type;

   // One classified command: the card byte or host word sits in data.
   typedef struct packed {
      cmd_kind_type           kind;
      logic [WORD_BITS-1:0]   data;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

   typedef struct packed {
      logic [BYTE_BITS-1:0]    card_byte_out;
      logic                    card_byte_valid;
      logic [WORD_BITS-1:0]    host_word_out;
      logic                    host_word_valid;
      logic [LEN_BITS-1:0]     bytes_left;
      logic [CNT_OUT_BITS-1:0] fifo_count;
      logic                    data_end;
      logic                    engine_active;
      logic                    fifo_empty;
      logic                    fifo_full;
      logic                    half_level;
   } rsp_type;

endpackage
`default_nettype wire

// File: rtl/sdf_channels.sv
// Handshake channel interfaces for the SD card data FIFO engine.
// Request and response words; no package dependency.
`default_nettype none
interface sdf_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  opcode;
   logic [7:0]  card_byte_in;
   logic [31:0] host_word_in;

   modport source (output valid, opcode, card_byte_in, host_word_in, input ready);
   modport sink   (input valid, opcode, card_byte_in, host_word_in, output ready);
endinterface

interface sdf_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  card_byte_out;
   logic        card_byte_valid;
   logic [31:0] host_word_out;
   logic        host_word_valid;
   logic [15:0] bytes_left;
   logic [4:0]  fifo_count;
   logic        data_end;
   logic        engine_active;
   logic        fifo_empty;
   logic        fifo_full;
   logic        half_level;

   modport source (output valid, card_byte_out, card_byte_valid, host_word_out,
                   host_word_valid, bytes_left, fifo_count, data_end, engine_active,
                   fifo_empty, fifo_full, half_level, input ready);
   modport sink   (input valid, card_byte_out, card_byte_valid, host_word_out,
                   host_word_valid, bytes_left, fifo_count, data_end, engine_active,
                   fifo_empty, fifo_full, half_level, output ready);
endinterface
`default_nettype wire

// File: rtl/sd_card_data_fifo_engine.sv
// Top level of the SD card data FIFO engine: register port, front end with
// its command queue, and back end. Uses sdf_pkg, sdf_channels, sdf_front, sdf_back.
`default_nettype none
//
//   port      | direction | content
//   ----------+-----------+------------------------------------------------
//   req_ch    | in        | opcode, card byte, host word; valid/ready
//   rsp_ch    | out       | card byte, host word, count, level, flags
//   psel ...  | in/out    | register port: direction, length, hold
//
// One request word is accepted per cycle while the command queue has room,
// and one response word leaves per cycle while rsp_ch.ready allows. A request
// waits in the two-entry command queue, and the back end registers its
// response when it takes the request from the queue.
// The back end stalls only on rsp_ch.ready; the queue absorbs two words.
// Reset is synchronous and clears all control state; the FIFO array is not
// cleared, as only written entries are ever read.
module sd_card_data_fifo_engine #(
   parameter int FIFO_DEPTH = 16,
   parameter int COUNT_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   sdf_req_if.sink          req_ch,
   sdf_rsp_if.source        rsp_ch,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import sdf_pkg::*;

   logic                direction_ff;
   logic [LEN_BITS-1:0] length_ff;
   logic                hold_ff;
   logic                wr_en;
   queue_head_type      q_head;
   logic                q_pop;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= 1'b0;
         length_ff    <= '0;
         hold_ff      <= 1'b0;
      end else if (wr_en) begin
         unique case (paddr[3:2])
            REG_DIRECTION: direction_ff <= pwdata[0];
            REG_LENGTH:    length_ff    <= pwdata[LEN_BITS-1:0];
            REG_HOLD:      hold_ff      <= pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_DIRECTION: prdata = {31'b0, direction_ff};
         REG_LENGTH:    prdata = {{(32-LEN_BITS){1'b0}}, length_ff};
         REG_HOLD:      prdata = {31'b0, hold_ff};
         default:       prdata = '0;
      endcase
   end

   sdf_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .q_pop  (q_pop),
      .q_head (q_head)
   );

   sdf_back #(
      .FIFO_DEPTH (FIFO_DEPTH),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .direction       (direction_ff),
      .transfer_length (length_ff),
      .hold_transfer   (hold_ff),
      .rsp_ch          (rsp_ch)
   );

endmodule
`default_nettype wire

// File: rtl/sdf_front.sv
// Front end: accepts request words, classifies the opcode into a command
// and holds it in a two-entry queue for the back end. Uses sdf_pkg, sdf_req_if.
`default_nettype none
module sdf_front (
   input  wire logic               clock,
   input  wire logic               reset,
   sdf_req_if.sink                 req_ch,
   input  wire logic               q_pop,
   output sdf_pkg::queue_head_type q_head
);
   import sdf_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   cmd_type    cmd;
   logic       push;
   logic       pop;

   always_comb begin
      cmd.data = req_ch.host_word_in;
      unique case (req_ch.opcode)
         OP_START:     cmd.kind = CMD_START;
         OP_CARD_IN: begin
            cmd.kind = CMD_CARD_IN;
            cmd.data = {{(WORD_BITS-BYTE_BITS){1'b0}}, req_ch.card_byte_in};
         end
         OP_CARD_REQ:  cmd.kind = CMD_CARD_REQ;
         OP_HOST_PUSH: cmd.kind = CMD_HOST_PUSH;
         OP_HOST_POP:  cmd.kind = CMD_HOST_POP;
         default:      cmd.kind = CMD_NONE;
      endcase
   end

   assign req_ch.ready = (count_ff != 2'd2);
   assign push         = req_ch.valid && req_ch.ready;
   assign pop          = q_pop && (count_ff != 2'd0);

   assign q_head.valid = (count_ff != 2'd0);
   assign q_head.cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule
`default_nettype wire

// File: rtl/sdf_back.sv
// Back end: while its last response is free to leave, carries out one command
// per cycle against the word FIFO, the byte count and the pack register, and
// registers the response word. Uses sdf_pkg and sdf_rsp_if.
`default_nettype none
module sdf_back #(
   parameter int FIFO_DEPTH = 16,
   parameter int COUNT_BITS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire sdf_pkg::queue_head_type     q_head,
   output logic                             q_pop,
   input  wire logic                        direction,
   input  wire logic [sdf_pkg::LEN_BITS-1:0] transfer_length,
   input  wire logic                        hold_transfer,
   sdf_rsp_if.source                        rsp_ch
);
   import sdf_pkg::*;

   localparam int AW   = $clog2(FIFO_DEPTH);
   localparam int LW   = $clog2(FIFO_DEPTH + 1);
   localparam int HALF = FIFO_DEPTH / 2;

   logic [WORD_BITS-1:0]  mem [FIFO_DEPTH];
   logic [WORD_BITS-1:0]  head_word_ff, head_word_in;
   logic [AW-1:0]         head_ff, head_in;
   logic [AW-1:0]         tail_ff, tail_in;
   logic [LW-1:0]         level_ff, level_in;
   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic [WORD_BITS-1:0]  pack_word_ff, pack_word_in;
   logic [2:0]            pack_bytes_ff, pack_bytes_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  fire;
   logic                  push;
   logic                  pop;
   logic                  full;
   logic                  empty;
   logic                  active;
   logic [COUNT_BITS-1:0] rem_dec;
   logic [WORD_BITS-1:0]  packed_word;
   logic [WORD_BITS-1:0]  send_word;
   logic [WORD_BITS-1:0]  push_data;
   logic [2:0]            bytes_inc;
   logic [31:0]           len_ext;
   logic [31:0]           rem_ext;
   logic [7:0]            level_ext;

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
      return (p == AW'(FIFO_DEPTH - 1)) ? '0 : p + AW'(1);
   endfunction

   assign fire  = q_head.valid && (!rsp_valid_ff || rsp_ch.ready);
   assign q_pop = fire;
   assign full  = (level_ff == LW'(FIFO_DEPTH));
   assign empty = (level_ff == '0);

   assign rem_dec     = rem_ff - COUNT_BITS'(1);
   assign bytes_inc   = pack_bytes_ff + 3'd1;
   assign packed_word = pack_word_ff
                        | (WORD_BITS'(q_head.cmd.data[BYTE_BITS-1:0])
                           << {pack_bytes_ff[1:0], 3'b000});
   // A fresh word is taken from the head of the FIFO when no popped bytes remain.
   assign send_word   = (pack_bytes_ff == 3'd0) ? head_word_ff : pack_word_ff;
   assign len_ext     = {{(32-LEN_BITS){1'b0}}, transfer_length};
   // Card bytes go into the FIFO as the packed word, host words as they come.
   assign push_data   = (q_head.cmd.kind == CMD_CARD_IN) ? packed_word : q_head.cmd.data;

   always_comb begin
      rem_in        = rem_ff;
      pack_word_in  = pack_word_ff;
      pack_bytes_in = pack_bytes_ff;
      push          = 1'b0;
      pop           = 1'b0;
      rsp_in        = '0;
      if (fire) begin
         unique case (q_head.cmd.kind)
            CMD_START: begin
               rem_in        = len_ext[COUNT_BITS-1:0];
               pack_word_in  = '0;
               pack_bytes_in = 3'd0;
            end
            CMD_CARD_IN: begin
               if (direction == DIR_FROM_CARD && !hold_transfer && rem_ff != '0 && !full) begin
                  rem_in = rem_dec;
                  if (bytes_inc >= BYTES_PER_WORD || rem_dec == '0) begin
                     push          = 1'b1;
                     pack_word_in  = '0;
                     pack_bytes_in = 3'd0;
                  end else begin
                     pack_word_in  = packed_word;
                     pack_bytes_in = bytes_inc;
                  end
               end
            end
            CMD_CARD_REQ: begin
               if (direction == DIR_TO_CARD && !hold_transfer && rem_ff != '0
                   && (pack_bytes_ff != 3'd0 || !empty)) begin
                  pop                    = (pack_bytes_ff == 3'd0);
                  rsp_in.card_byte_out   = send_word[BYTE_BITS-1:0];
                  rsp_in.card_byte_valid = 1'b1;
                  rem_in                 = rem_dec;
                  if (rem_dec == '0) begin
                     // The count ran out: unsent bytes of the word are dropped.
                     pack_word_in  = '0;
                     pack_bytes_in = 3'd0;
                  end else begin
                     pack_word_in  = send_word >> BYTE_BITS;
                     pack_bytes_in = ((pack_bytes_ff == 3'd0) ? BYTES_PER_WORD
                                                              : pack_bytes_ff) - 3'd1;
                  end
               end
            end
            CMD_HOST_PUSH: begin
               push = (direction == DIR_TO_CARD) && !full;
            end
            CMD_HOST_POP: begin
               if (direction == DIR_FROM_CARD && !empty) begin
                  pop                    = 1'b1;
                  rsp_in.host_word_out   = head_word_ff;
                  rsp_in.host_word_valid = 1'b1;
               end
            end
            CMD_NONE: begin
            end
            default: begin
            end
         endcase
      end

      tail_in  = push ? wrap_inc(tail_ff) : tail_ff;
      head_in  = pop ? wrap_inc(head_ff) : head_ff;
      level_in = push ? level_ff + LW'(1) : (pop ? level_ff - LW'(1) : level_ff);

      active    = (rem_in != '0) || (level_in != '0);
      rem_ext   = 32'(rem_in);
      level_ext = 8'(level_in);
      rsp_in.bytes_left    = rem_ext[LEN_BITS-1:0];
      rsp_in.fifo_count    = level_ext[CNT_OUT_BITS-1:0];
      rsp_in.data_end      = (rem_in == '0);
      rsp_in.engine_active = active;
      rsp_in.fifo_empty    = active && (level_in == '0);
      rsp_in.fifo_full     = active && (level_in == LW'(FIFO_DEPTH));
      rsp_in.half_level    = active && ((direction == DIR_FROM_CARD) ?
                                        (level_in >= LW'(HALF)) : (level_in <= LW'(HALF)));

      rsp_valid_in = fire ? 1'b1 : (rsp_valid_ff && !rsp_ch.ready);
   end

   // The head word register always holds the entry at the head pointer after
   // this cycle; a word written into that entry now is forwarded.
   assign head_word_in = (push && tail_ff == head_in) ? push_data : mem[head_in];

   always_ff @(posedge clock) begin
      if (push) begin
         mem[tail_ff] <= push_data;
      end
      head_word_ff <= head_word_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         tail_ff       <= '0;
         level_ff      <= '0;
         rem_ff        <= '0;
         pack_word_ff  <= '0;
         pack_bytes_ff <= 3'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         level_ff      <= level_in;
         rem_ff        <= rem_in;
         pack_word_ff  <= pack_word_in;
         pack_bytes_ff <= pack_bytes_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.card_byte_out   = rsp_ff.card_byte_out;
   assign rsp_ch.card_byte_valid = rsp_ff.card_byte_valid;
   assign rsp_ch.host_word_out   = rsp_ff.host_word_out;
   assign rsp_ch.host_word_valid = rsp_ff.host_word_valid;
   assign rsp_ch.bytes_left      = rsp_ff.bytes_left;
   assign rsp_ch.fifo_count      = rsp_ff.fifo_count;
   assign rsp_ch.data_end        = rsp_ff.data_end;
   assign rsp_ch.engine_active   = rsp_ff.engine_active;
   assign rsp_ch.fifo_empty      = rsp_ff.fifo_empty;
   assign rsp_ch.fifo_full       = rsp_ff.fifo_full;
   assign rsp_ch.half_level      = rsp_ff.half_level;

endmodule
`default_nettype wire

// File: bench/testbench.sv
// Self-checking bench for sd_card_data_fifo_engine: a tracker class predicts
// every response word from the request words accepted. Depends on sdf_pkg,
// the channel interfaces in sdf_channels and the engine itself.
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import sdf_pkg::*;

   localparam int FIFO_SLOTS   = 16;
   localparam int TARGET_WORDS = 850;
   localparam int DRAIN_CYCLES = 6;
   localparam int CYCLE_LIMIT  = 500000;
   localparam logic [2:0] OP_SPARE_LO = 3'd5;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   // Tracks the engine's FIFO, byte count and packing state, and keeps the
   // responses still owed in order.
   class transfer_tracker;
      logic [31:0] slots [FIFO_SLOTS];
      int unsigned level, head, tail;
      logic [15:0] left;
      logic [31:0] shift_word;
      logic [2:0]  shift_bytes;
      logic        dir, hold;
      logic [15:0] length;
      rsp_type     owed_q[$];
      int unsigned mismatches, useful_words, checked, accepted;

      function new();
         level = 0; head = 0; tail = 0;
         left = '0; shift_word = '0; shift_bytes = '0;
         dir = DIR_TO_CARD; hold = 1'b0; length = '0;
         mismatches = 0; useful_words = 0; checked = 0; accepted = 0;
      endfunction

      function void set_register(logic [1:0] index, logic [31:0] value);
         case (index)
            REG_DIRECTION: dir = value[0];
            REG_LENGTH:    length = value[15:0];
            REG_HOLD:      hold = value[0];
            default: ;
         endcase
      endfunction

      function void push_word(logic [31:0] w);
         if (level < FIFO_SLOTS) begin
            slots[tail] = w;
            tail = (tail + 1) % FIFO_SLOTS;
            level++;
         end
      endfunction

      function logic [31:0] pop_word();
         logic [31:0] w;
         w = slots[head];
         head = (head + 1) % FIFO_SLOTS;
         level--;
         return w;
      endfunction

      function void note_request(logic [2:0] op, logic [7:0] cbyte, logic [31:0] hword);
         rsp_type     want;
         logic [15:0] left_was;
         int unsigned level_was;
         logic [31:0] shift_was;
         logic [2:0]  bytes_was;
         bit          active;
         want = '0;
         left_was = left;
         level_was = level;
         shift_was = shift_word;
         bytes_was = shift_bytes;
         accepted++;
         case (op)
            OP_START: begin
               left = length;
               shift_word = '0;
               shift_bytes = '0;
            end
            OP_CARD_IN:
               if (dir == DIR_FROM_CARD && !hold && left != 0 && level < FIFO_SLOTS) begin
                  shift_word |= 32'(cbyte) << (8 * shift_bytes[1:0]);
                  shift_bytes++;
                  left--;
                  // A word goes in when full, or early on the last byte.
                  if (shift_bytes >= BYTES_PER_WORD || left == 0) begin
                     push_word(shift_word);
                     shift_word = '0;
                     shift_bytes = '0;
                  end
               end
            OP_CARD_REQ:
               if (dir == DIR_TO_CARD && !hold && left != 0 &&
                   (shift_bytes != 0 || level != 0)) begin
                  if (shift_bytes == 0) begin
                     shift_word = pop_word();
                     shift_bytes = BYTES_PER_WORD;
                  end
                  want.card_byte_out = shift_word[7:0];
                  want.card_byte_valid = 1'b1;
                  shift_word >>= 8;
                  shift_bytes--;
                  left--;
                  // Bytes of a word still unsent when the count runs out are lost.
                  if (left == 0) begin
                     shift_word = '0;
                     shift_bytes = '0;
                  end
               end
            OP_HOST_PUSH:
               if (dir == DIR_TO_CARD) push_word(hword);
            OP_HOST_POP:
               if (dir == DIR_FROM_CARD && level != 0) begin
                  want.host_word_out = pop_word();
                  want.host_word_valid = 1'b1;
               end
            default: ;
         endcase
         active = (left != 0) || (level != 0);
         want.bytes_left = left;
         want.fifo_count = 5'(level);
         want.data_end = (left == 0);
         want.engine_active = active;
         want.fifo_empty = active && level == 0;
         want.fifo_full = active && level == FIFO_SLOTS;
         if (dir == DIR_FROM_CARD)
            want.half_level = active && level >= FIFO_SLOTS / 2;
         else
            want.half_level = active && level <= FIFO_SLOTS / 2;
         owed_q.push_back(want);
         if (op == OP_START || want.card_byte_valid || want.host_word_valid ||
             left != left_was || level != level_was || shift_word != shift_was ||
             shift_bytes != bytes_was)
            useful_words++;
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %h, got %h", $time, field, want, got);
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (owed_q.size() == 0) begin
            mismatches++;
            $display("%0t: response word with none expected, got %h", $time, got);
         end else begin
            want = owed_q.pop_front();
            checked++;
            compare_field("card_byte_out", 32'(want.card_byte_out), 32'(got.card_byte_out));
            compare_field("card_byte_valid", 32'(want.card_byte_valid),
                          32'(got.card_byte_valid));
            compare_field("host_word_out", want.host_word_out, got.host_word_out);
            compare_field("host_word_valid", 32'(want.host_word_valid),
                          32'(got.host_word_valid));
            compare_field("bytes_left", 32'(want.bytes_left), 32'(got.bytes_left));
            compare_field("fifo_count", 32'(want.fifo_count), 32'(got.fifo_count));
            compare_field("data_end", 32'(want.data_end), 32'(got.data_end));
            compare_field("engine_active", 32'(want.engine_active), 32'(got.engine_active));
            compare_field("fifo_empty", 32'(want.fifo_empty), 32'(got.fifo_empty));
            compare_field("fifo_full", 32'(want.fifo_full), 32'(got.fifo_full));
            compare_field("half_level", 32'(want.half_level), 32'(got.half_level));
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        psel, penable, pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   sdf_req_if req_bus ();
   sdf_rsp_if rsp_bus ();

   transfer_tracker tracker;
   int sender_idle_pct;
   int sink_stall_pct;
   int hold_off_cycles;
   int cycle_count;
   int transfers;

   sd_card_data_fifo_engine u_top (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_bus),
      .rsp_ch  (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Both handshakes are sampled here, request first.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            tracker.note_request(req_bus.opcode, req_bus.card_byte_in, req_bus.host_word_in);
         if (rsp_bus.valid && rsp_bus.ready)
            tracker.check_response(rsp_type'({rsp_bus.card_byte_out, rsp_bus.card_byte_valid,
               rsp_bus.host_word_out, rsp_bus.host_word_valid, rsp_bus.bytes_left,
               rsp_bus.fifo_count, rsp_bus.data_end, rsp_bus.engine_active,
               rsp_bus.fifo_empty, rsp_bus.fifo_full, rsp_bus.half_level}));
      end
   end

   // Response side: random stalls, or a long hold-off when one is requested.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_off_cycles--;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
         end
      end
   end

   task automatic send_word(logic [2:0] op, logic [7:0] cbyte, logic [31:0] hword);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.opcode <= op;
      req_bus.card_byte_in <= cbyte;
      req_bus.host_word_in <= hword;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (tracker.owed_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [1:0] index, logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      tracker.set_register(index, value);
   endtask

   // One transfer: program the registers, start, then a mix of words that
   // suits the direction with some stray opcodes thrown in.
   task automatic run_transfer(logic dir_sel, logic [15:0] len, bit held, int ops);
      int n;
      int r;
      logic [2:0] op;
      wait_for_results();
      write_register(REG_DIRECTION, 32'(dir_sel));
      write_register(REG_LENGTH, 32'(len));
      write_register(REG_HOLD, 32'(held));
      send_word(OP_START, 8'($urandom_range(255)), $urandom);
      for (n = 0; n < ops; n++) begin
         if (held && n == ops / 2) begin
            wait_for_results();
            write_register(REG_HOLD, 32'd0);
         end
         r = $urandom_range(99);
         if (dir_sel == DIR_TO_CARD)
            op = (r < 35) ? OP_HOST_PUSH : (r < 85) ? OP_CARD_REQ :
                 (r < 88) ? OP_HOST_POP : (r < 91) ? OP_CARD_IN :
                 (r < 93) ? OP_START : 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
         else
            op = (r < 50) ? OP_CARD_IN : (r < 85) ? OP_HOST_POP :
                 (r < 88) ? OP_HOST_PUSH : (r < 91) ? OP_CARD_REQ :
                 (r < 93) ? OP_START : 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
         send_word(op, 8'($urandom_range(255)), $urandom);
      end
   endtask

   initial begin
      int phase;
      int r;
      logic [15:0] len;
      int ops;
      tracker = new();
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.opcode = OP_START;
      req_bus.card_byte_in = '0;
      req_bus.host_word_in = '0;
      sender_idle_pct = 0;
      sink_stall_pct = 0;
      hold_off_cycles = 0;
      cycle_count = 0;
      transfers = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: stray opcode and refused requests with nothing loaded.
      write_register(REG_DIRECTION, 32'(DIR_TO_CARD));
      write_register(REG_LENGTH, 32'd5);
      write_register(REG_HOLD, 32'd0);
      send_word(OP_SPARE_LO, 8'hff, 32'hffff_ffff);
      send_word(OP_CARD_REQ, 8'h00, 32'h0);
      send_word(OP_HOST_POP, 8'h00, 32'h0);
      send_word(OP_CARD_IN, 8'hab, 32'h0);
      // Five bytes out of two words: the count ends part way through the second.
      send_word(OP_START, 8'h00, 32'h0);
      send_word(OP_HOST_PUSH, 8'h00, 32'hffff_ffff);
      send_word(OP_HOST_PUSH, 8'h00, 32'h0000_0000);
      repeat (6) send_word(OP_CARD_REQ, 8'h00, 32'h0);

      // Held transfer of the longest length, then released.
      wait_for_results();
      write_register(REG_HOLD, 32'd1);
      write_register(REG_LENGTH, 32'hffff);
      send_word(OP_START, 8'h00, 32'h0);
      send_word(OP_HOST_PUSH, 8'h00, 32'h8000_0001);
      send_word(OP_CARD_REQ, 8'h00, 32'h0);
      wait_for_results();
      write_register(REG_HOLD, 32'd0);
      send_word(OP_CARD_REQ, 8'h00, 32'h0);

      // Read direction: one full word, then a single trailing byte.
      wait_for_results();
      write_register(REG_DIRECTION, 32'(DIR_FROM_CARD));
      write_register(REG_LENGTH, 32'd5);
      send_word(OP_START, 8'h00, 32'h0);
      send_word(OP_CARD_IN, 8'hff, 32'h0);
      send_word(OP_CARD_IN, 8'h00, 32'h0);
      send_word(OP_CARD_IN, 8'h80, 32'h0);
      send_word(OP_CARD_IN, 8'h7f, 32'h0);
      send_word(OP_CARD_IN, 8'h01, 32'h0);
      send_word(OP_HOST_PUSH, 8'h00, 32'hdead_beef);
      repeat (3) send_word(OP_HOST_POP, 8'h00, 32'h0);

      while (tracker.accepted < TARGET_WORDS) begin
         phase = (tracker.accepted * 4) / TARGET_WORDS;
         case (phase)
            0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin sender_idle_pct = 86; sink_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  sink_stall_pct = 86; end
            default: begin sender_idle_pct = 27; sink_stall_pct = 27; end
         endcase
         r = $urandom_range(99);
         if (r < 5)
            len = 16'd0;
         else if (r < 9)
            len = 16'hffff;
         else if (r < 20)
            len = 16'($urandom_range(300, 49));
         else
            len = 16'($urandom_range(48, 1));
         ops = int'(len) + int'(len) / 3 + $urandom_range(6, 2);
         if (ops > 160) ops = 160;
         // Early on, the response side stops for a long while so the engine
         // backs up and has to refuse requests.
         if (transfers == 1) begin
            hold_off_cycles = 60;
            len = 16'd64;
            ops = 80;
         end
         run_transfer(1'($urandom_range(1)), len, ($urandom_range(9) == 0), ops);
         transfers++;
      end

      wait_for_results();
      $display("Covered %0d transfers in both directions over four idling phases.",
               transfers);
      $display("%0d request words, %0d state-changing, %0d responses checked, %0d cycles.",
               tracker.accepted, tracker.useful_words, tracker.checked, cycle_count);
      if (tracker.mismatches == 0 && tracker.owed_q.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches, %0d responses never arrived",
                  tracker.mismatches, tracker.owed_q.size());
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
`default_nettype wire

// File: filelist.f
rtl/sdf_pkg.sv
rtl/sdf_channels.sv
rtl/sdf_front.sv
rtl/sdf_back.sv
rtl/sd_card_data_fifo_engine.sv
bench/testbench.sv
